// ----- design/sliding_window_min_max_average_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window min/max/average block
// Shared concurrent-assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_AVERAGE_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define SWMMA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("sliding window check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define SWMMA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("sliding window sequence check failed");

`endif

// ----- design/swmma_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window min/max/average package
// Control word layout, status bundle and micro-op codes shared by the
// sequencer and the datapath, and the jump codes and microcode program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package swmma_pkg;

    // Configuration register width and its value after reset.
    localparam int          CFG_W         = 7;
    localparam logic [6:0]  WINDOW_RESET  = 7'd64;

    // Program counter width and step addresses.
    localparam int              STEP_W        = 3;
    localparam logic [2:0]      ST_ACCEPT     = 3'd0;
    localparam logic [2:0]      ST_PUSH_ADDR  = 3'd1;
    localparam logic [2:0]      ST_PUSH_SUM   = 3'd2;
    localparam logic [2:0]      ST_SCAN_START = 3'd3;
    localparam logic [2:0]      ST_SCAN       = 3'd4;
    localparam logic [2:0]      ST_DIV_INIT   = 3'd5;
    localparam logic [2:0]      ST_DIV        = 3'd6;
    localparam logic [2:0]      ST_EMIT       = 3'd7;

    // Datapath micro-operations.
    localparam int              OP_W          = 3;
    localparam logic [2:0]      OP_ACCEPT     = 3'd0;
    localparam logic [2:0]      OP_PUSH_ADDR  = 3'd1;
    localparam logic [2:0]      OP_PUSH_SUM   = 3'd2;
    localparam logic [2:0]      OP_SCAN_START = 3'd3;
    localparam logic [2:0]      OP_SCAN       = 3'd4;
    localparam logic [2:0]      OP_DIV_INIT   = 3'd5;
    localparam logic [2:0]      OP_DIV        = 3'd6;
    localparam logic [2:0]      OP_EMIT       = 3'd7;

    // Jump conditions; a jump goes to the target, otherwise the counter steps.
    localparam int              COND_W         = 3;
    localparam logic [2:0]      COND_NONE      = 3'd0;
    localparam logic [2:0]      COND_NO_INPUT  = 3'd1;
    localparam logic [2:0]      COND_SCAN_MORE = 3'd2;
    localparam logic [2:0]      COND_DIV_MORE  = 3'd3;
    localparam logic [2:0]      COND_OUT_BUSY  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic accepted;
        logic scan_more;
        logic div_more;
        logic out_busy;
    } dp_status_t;

    // Microcode program. The last step falls through and the counter wraps
    // back to the accept step.
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            ST_ACCEPT:     w = '{op: OP_ACCEPT,     cond: COND_NO_INPUT,  target: ST_ACCEPT};
            ST_PUSH_ADDR:  w = '{op: OP_PUSH_ADDR,  cond: COND_NONE,      target: ST_ACCEPT};
            ST_PUSH_SUM:   w = '{op: OP_PUSH_SUM,   cond: COND_NONE,      target: ST_ACCEPT};
            ST_SCAN_START: w = '{op: OP_SCAN_START, cond: COND_NONE,      target: ST_ACCEPT};
            ST_SCAN:       w = '{op: OP_SCAN,       cond: COND_SCAN_MORE, target: ST_SCAN};
            ST_DIV_INIT:   w = '{op: OP_DIV_INIT,   cond: COND_NONE,      target: ST_ACCEPT};
            ST_DIV:        w = '{op: OP_DIV,        cond: COND_DIV_MORE,  target: ST_DIV};
            ST_EMIT:       w = '{op: OP_EMIT,       cond: COND_OUT_BUSY,  target: ST_EMIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/swmma_sequencer.sv -----
// ----------------------------------------------------------------------------
// Sliding window microcode sequencer
// Program counter, control store lookup and conditional jump evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_min_max_average_defines.svh"

module swmma_sequencer (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire swmma_pkg::dp_status_t status,
    output swmma_pkg::ctrl_word_t      ctrl
);

    logic [swmma_pkg::STEP_W-1:0] step_reg;
    logic [swmma_pkg::STEP_W-1:0] step_next;
    logic                         take_jump;

    // Fetch the control word of the current step.
    assign ctrl = swmma_pkg::ucode_rom(step_reg);

    // Evaluate the jump condition against datapath status.
    always_comb begin
        unique case (ctrl.cond)
            swmma_pkg::COND_NONE:      take_jump = 1'b0;
            swmma_pkg::COND_NO_INPUT:  take_jump = !status.accepted;
            swmma_pkg::COND_SCAN_MORE: take_jump = status.scan_more;
            swmma_pkg::COND_DIV_MORE:  take_jump = status.div_more;
            swmma_pkg::COND_OUT_BUSY:  take_jump = status.out_busy;
            default:                   take_jump = 1'b0;
        endcase
        step_next = take_jump ? ctrl.target : step_reg + swmma_pkg::STEP_W'(1);
    end

    // Program counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= swmma_pkg::ST_ACCEPT;
        end else begin
            step_reg <= step_next;
        end
    end

    // An accepted transaction always moves on to the push step.
    `SWMMA_ASSERT_NXT(a_accept_to_push, status.accepted, step_reg == swmma_pkg::ST_PUSH_ADDR)

endmodule

`default_nettype wire

// ----- design/swmma_datapath.sv -----
// ----------------------------------------------------------------------------
// Sliding window datapath
// Sample ring memory, running sum, min/max scan, serial divider and the
// output register, each driven by the current micro-operation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_min_max_average_defines.svh"

module swmma_datapath #(
    parameter int DEPTH        = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire swmma_pkg::ctrl_word_t                ctrl,
    output swmma_pkg::dp_status_t                     status,
    input  wire logic [$clog2(DEPTH+1)-1:0]           eff_len,
    input  wire logic                                 cfg_write,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       s_sample,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]            m_average,
    output logic signed [SAMPLE_WIDTH-1:0]            m_minimum,
    output logic signed [SAMPLE_WIDTH-1:0]            m_maximum,
    output logic [$clog2(DEPTH+1)-1:0]                m_count,
    output logic                                      m_full_res
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = SAMPLE_WIDTH + $clog2(DEPTH);
    localparam int BCW  = $clog2(SUMW + 1);

    // Sample ring.
    logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                           mem_we;
    logic                           mem_re;
    logic [PW-1:0]                  rd_addr;

    // Window state.
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [PW-1:0]                  newest_reg, newest_next;
    logic [PW-1:0]                  target_reg, target_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic signed [SUMW-1:0]         sum_reg, sum_next;
    logic                           was_full_reg, was_full_next;

    // Scan state.
    logic [CW-1:0]                  idx_reg, idx_next;
    logic signed [SAMPLE_WIDTH-1:0] min_reg, min_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg, max_next;

    // Divider state.
    logic [SUMW-1:0]                mag_reg, mag_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic                           neg_reg, neg_next;
    logic [BCW-1:0]                 bit_cnt_reg, bit_cnt_next;

    // Output register.
    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] avg_out_reg, avg_out_next;
    logic signed [SAMPLE_WIDTH-1:0] min_out_reg, min_out_next;
    logic signed [SAMPLE_WIDTH-1:0] max_out_reg, max_out_next;
    logic [CW-1:0]                  cnt_out_reg, cnt_out_next;
    logic                           full_out_reg, full_out_next;

    // Helpers.
    logic                           accepted;
    logic                           out_free;
    logic [CW-1:0]                  newest_inc;
    logic [PW-1:0]                  newest_adv;
    logic signed [SUMW-1:0]         sample_ext;
    logic signed [SUMW-1:0]         old_ext;
    logic [SUMW-1:0]                sum_abs;
    logic [CW:0]                    div_shift;
    logic [CW:0]                    div_diff;
    logic                           div_ge;
    logic [SAMPLE_WIDTH-1:0]        quot_trunc;

    // A pending configuration write holds off the input for that cycle.
    assign s_ready  = (ctrl.op == swmma_pkg::OP_ACCEPT) && !cfg_write;
    assign accepted = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign status.accepted  = accepted;
    assign status.scan_more = idx_reg < count_reg;
    assign status.div_more  = bit_cnt_reg > BCW'(1);
    assign status.out_busy  = !out_free;

    // Ring pointer advance, wrapping at the effective window length.
    assign newest_inc = CW'(newest_reg) + CW'(1);
    assign newest_adv = (newest_inc >= eff_len) ? '0 : newest_inc[PW-1:0];

    // Sign extensions into the sum width.
    assign sample_ext = {{(SUMW-SAMPLE_WIDTH){sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};
    assign old_ext    = was_full_reg ?
                        {{(SUMW-SAMPLE_WIDTH){rd_data_reg[SAMPLE_WIDTH-1]}}, rd_data_reg} :
                        '0;
    assign sum_abs    = sum_reg[SUMW-1] ? (SUMW'(~sum_reg) + SUMW'(1)) : SUMW'(sum_reg);

    // One restoring division step on the magnitude.
    assign div_shift  = {rem_reg, mag_reg[SUMW-1]};
    assign div_ge     = div_shift >= {1'b0, count_reg};
    assign div_diff   = div_shift - {1'b0, count_reg};
    assign quot_trunc = mag_reg[SAMPLE_WIDTH-1:0];

    // Micro-operation decode.
    always_comb begin
        newest_next   = newest_reg;
        target_next   = target_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        was_full_next = was_full_reg;
        idx_next      = idx_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        bit_cnt_next  = bit_cnt_reg;
        avg_out_next  = avg_out_reg;
        min_out_next  = min_out_reg;
        max_out_next  = max_out_reg;
        cnt_out_next  = cnt_out_reg;
        full_out_next = full_out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_addr       = '0;

        unique case (ctrl.op)
            swmma_pkg::OP_ACCEPT: begin
                // Sample is latched in the clocked block on acceptance.
            end
            swmma_pkg::OP_PUSH_ADDR: begin
                // Pick the slot for the new sample and fetch what it holds.
                if (count_reg == '0) begin
                    target_next   = newest_reg;
                    was_full_next = 1'b0;
                    count_next    = CW'(1);
                end else if (count_reg >= eff_len) begin
                    target_next   = newest_adv;
                    was_full_next = 1'b1;
                    count_next    = eff_len;
                end else begin
                    target_next   = newest_adv;
                    was_full_next = 1'b0;
                    count_next    = count_reg + CW'(1);
                end
                newest_next = target_next;
                mem_re      = 1'b1;
                rd_addr     = target_next;
            end
            swmma_pkg::OP_PUSH_SUM: begin
                // Drop the evicted sample from the sum and store the new one.
                sum_next = sum_reg + sample_ext - old_ext;
                mem_we   = 1'b1;
            end
            swmma_pkg::OP_SCAN_START: begin
                mem_re   = 1'b1;
                rd_addr  = '0;
                idx_next = CW'(1);
            end
            swmma_pkg::OP_SCAN: begin
                // Compare the entry read last cycle and fetch the next one.
                if (idx_reg == CW'(1)) begin
                    min_next = rd_data_reg;
                    max_next = rd_data_reg;
                end else begin
                    min_next = (rd_data_reg < min_reg) ? rd_data_reg : min_reg;
                    max_next = (rd_data_reg > max_reg) ? rd_data_reg : max_reg;
                end
                mem_re   = idx_reg < count_reg;
                rd_addr  = idx_reg[PW-1:0];
                idx_next = idx_reg + CW'(1);
            end
            swmma_pkg::OP_DIV_INIT: begin
                neg_next     = sum_reg[SUMW-1];
                mag_next     = sum_abs;
                rem_next     = '0;
                bit_cnt_next = BCW'(SUMW);
            end
            swmma_pkg::OP_DIV: begin
                rem_next     = div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
                mag_next     = {mag_reg[SUMW-2:0], div_ge};
                bit_cnt_next = bit_cnt_reg - BCW'(1);
            end
            swmma_pkg::OP_EMIT: begin
                // Load the result once the output register is free.
                if (out_free) begin
                    avg_out_next  = neg_reg ? SAMPLE_WIDTH'(~quot_trunc + 1'b1) : quot_trunc;
                    min_out_next  = min_reg;
                    max_out_next  = max_reg;
                    cnt_out_next  = count_reg;
                    full_out_next = count_reg == eff_len;
                    m_valid_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // A configuration write empties the window.
        if (cfg_write) begin
            newest_next = '0;
            count_next  = '0;
            sum_next    = '0;
        end
    end

    // Ring memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[target_reg] <= sample_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            newest_reg  <= newest_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accepted) begin
            sample_reg <= s_sample;
        end
        target_reg   <= target_next;
        was_full_reg <= was_full_next;
        idx_reg      <= idx_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        bit_cnt_reg  <= bit_cnt_next;
        avg_out_reg  <= avg_out_next;
        min_out_reg  <= min_out_next;
        max_out_reg  <= max_out_next;
        cnt_out_reg  <= cnt_out_next;
        full_out_reg <= full_out_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_average  = avg_out_reg;
    assign m_minimum  = min_out_reg;
    assign m_maximum  = max_out_reg;
    assign m_count    = cnt_out_reg;
    assign m_full_res = full_out_reg;

    // The fill count never runs past the window length.
    `SWMMA_ASSERT_IMP(a_count_in_window, 1'b1, count_reg <= eff_len)
    // The divider has used up all quotient bits before a result is loaded.
    `SWMMA_ASSERT_IMP(a_div_done, ctrl.op == swmma_pkg::OP_EMIT, bit_cnt_reg == '0)
    // The scan leaves a consistent minimum and maximum.
    `SWMMA_ASSERT_IMP(a_min_le_max, ctrl.op == swmma_pkg::OP_EMIT, min_reg <= max_reg)
    // A presented result always covers at least one sample.
    `SWMMA_ASSERT_IMP(a_out_count_nonzero, m_valid_reg, cnt_out_reg != '0)

endmodule

`default_nettype wire

// ----- design/sliding_window_min_max_average.sv -----
// ----------------------------------------------------------------------------
// Sliding window min/max/average
// Top level: configuration register, window length limits, sequencer and
// datapath.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the s_ channel and one result per sample leaves on the
// m_ channel: the truncated average, minimum and maximum over the window,
// the fill count and a full flag. The cfg_ channel writes the window length;
// a write empties the window, and a length of zero or above DEPTH means
// DEPTH. Write the length only while no sample is in flight.
// Each sample passes the push steps, a min/max scan over the fill count of
// ring entries and a serial division of the sum over SUMW quotient bits,
// where SUMW is SAMPLE_WIDTH plus log2(DEPTH) (22 by default), before the
// load step sets m_valid. The min/max scan reads one ring entry per cycle
// and the divider retires one quotient bit per cycle; the next sample is
// taken only after the sequencer returns to the accept step.
// Reset clears the window and sets the length to 64; no result is pending.
// When the receiver stalls, the result holds in the output register; the next
// sample is still taken and processed, and waits only at the load step.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max_average #(
    parameter int DEPTH        = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   s_sample,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        m_average,
    output logic signed [SAMPLE_WIDTH-1:0]        m_minimum,
    output logic signed [SAMPLE_WIDTH-1:0]        m_maximum,
    output logic [$clog2(DEPTH+1)-1:0]            m_count,
    output logic                                  m_full_res,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [swmma_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [swmma_pkg::CFG_W-1:0] window_length_reg;
    logic [CW-1:0]               eff_len;
    logic                        cfg_write;
    swmma_pkg::ctrl_word_t       ctrl;
    swmma_pkg::dp_status_t       status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Window length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= swmma_pkg::WINDOW_RESET;
        end else if (cfg_write) begin
            window_length_reg <= cfg_data;
        end
    end

    // Zero or an oversized length selects the full ring.
    assign eff_len = ((window_length_reg == '0) || (int'(window_length_reg) > DEPTH)) ?
                     CW'(DEPTH) : CW'(window_length_reg);

    swmma_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    swmma_datapath #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .status     (status),
        .eff_len    (eff_len),
        .cfg_write  (cfg_write),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_average  (m_average),
        .m_minimum  (m_minimum),
        .m_maximum  (m_maximum),
        .m_count    (m_count),
        .m_full_res (m_full_res)
    );

endmodule

`default_nettype wire
